@@ rtl/c8wd_pkg.sv @@
package c8wd_pkg;

	localparam logic [7:0] CrcPoly = 8'h31;
	localparam logic [7:0] CrcInit = 8'hFF;
	localparam logic [7:0] CrcTop = 8'h80;
	localparam logic [6:0] CountMax = 7'd127;
	localparam int QueueDepthDef = 4;

	// one checked triplet on its way from the front to the back
	typedef struct packed {
		logic fresh;
		logic ok;
		logic [15:0] word;
		logic [7:0] calc;
		logic [7:0] recv;
	} evt_t;

	// msb-first crc-8 update over one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CrcTop) != 8'h00) begin
				c = (c << 1) ^ CrcPoly;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/crc8_checked_word_deframer_top.sv @@
// channel  direction  handshake               payload
// in       input      in_valid / in_stall     rx_byte, start_of_read
// out      output     out_valid / out_stall   word_value, crc_ok, computed_crc,
//                                             received_crc, word_index
// cfg      input      cfg_valid / cfg_ready   cfg_data (pair_mode)
//
// one byte per cycle while in_stall is low; a triplet's result is written to the queue
// when its closing byte is accepted, then taken into the back output register
// reset clears phase, abort, pending half word, count and the queue; pair_mode resets to 1
// in_stall rises only when the queue between front and back is full;
// the back keeps taking from the queue while the output register drains
module crc8_checked_word_deframer_top #(
	parameter int QueueDepth = c8wd_pkg::QueueDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] rx_byte,
	input  logic start_of_read,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] word_value,
	output logic crc_ok,
	output logic [7:0] computed_crc,
	output logic [7:0] received_crc,
	output logic [6:0] word_index,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	import c8wd_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_pop;
	logic evt_push;
	evt_t evt;
	evt_t head;

	c8wd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.start_of_read(start_of_read),
		.q_full(q_full),
		.evt_push(evt_push),
		.evt(evt)
	);

	c8wd_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(evt_push),
		.push_evt(evt),
		.full(q_full),
		.pop(q_pop),
		.head(head),
		.empty(q_empty)
	);

	c8wd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.q_empty(q_empty),
		.head(head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_value(word_value),
		.crc_ok(crc_ok),
		.computed_crc(computed_crc),
		.received_crc(received_crc),
		.word_index(word_index)
	);

endmodule

@@ rtl/c8wd_front.sv @@
module c8wd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] rx_byte,
	input  logic start_of_read,
	input  logic q_full,
	output logic evt_push,
	output c8wd_pkg::evt_t evt
);
	import c8wd_pkg::*;

	logic [1:0] phase_q;
	logic aborted_q;
	logic fresh_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic [7:0] crc_q;

	logic accept;
	logic [1:0] phase_eff;
	logic aborted_eff;
	logic fresh_eff;
	logic crc_match;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	// a start byte clears phase and abort before the byte itself is used
	always_comb begin
		phase_eff = start_of_read ? 2'd0 : phase_q;
		if (phase_eff == 2'd3) begin
			phase_eff = 2'd0;
		end
		aborted_eff = start_of_read ? 1'b0 : aborted_q;
		fresh_eff = start_of_read ? 1'b1 : fresh_q;
	end

	assign crc_match = (crc_q == rx_byte);
	assign evt_push = accept && !aborted_eff && (phase_eff == 2'd2);

	always_comb begin
		evt.fresh = fresh_eff;
		evt.ok = crc_match;
		evt.word = {first_q, second_q};
		evt.calc = crc_q;
		evt.recv = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			aborted_q <= 1'b0;
			fresh_q <= 1'b0;
		end else if (accept) begin
			fresh_q <= fresh_eff;
			aborted_q <= aborted_eff;
			phase_q <= phase_eff;
			if (!aborted_eff) begin
				case (phase_eff)
					2'd0: phase_q <= 2'd1;
					2'd1: phase_q <= 2'd2;
					default: begin
						phase_q <= 2'd0;
						fresh_q <= 1'b0;
						aborted_q <= !crc_match;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !aborted_eff) begin
			case (phase_eff)
				2'd0: begin
					first_q <= rx_byte;
					crc_q <= crc8_byte(CrcInit, rx_byte);
				end
				2'd1: begin
					second_q <= rx_byte;
					crc_q <= crc8_byte(crc_q, rx_byte);
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/c8wd_queue.sv @@
module c8wd_queue #(
	parameter int Depth = c8wd_pkg::QueueDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  c8wd_pkg::evt_t push_evt,
	output logic full,
	input  logic pop,
	output c8wd_pkg::evt_t head,
	output logic empty
);
	import c8wd_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	evt_t mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CntW'(Depth));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_evt;
		end
	end

endmodule

@@ rtl/c8wd_back.sv @@
module c8wd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data,
	input  logic q_empty,
	input  c8wd_pkg::evt_t head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] word_value,
	output logic crc_ok,
	output logic [7:0] computed_crc,
	output logic [7:0] received_crc,
	output logic [6:0] word_index
);
	import c8wd_pkg::*;

	logic pair_mode_q;
	logic half_q;
	logic [15:0] upper_q;
	logic [6:0] count_q;
	logic out_valid_q;
	logic [31:0] word_q;
	logic ok_q;
	logic [7:0] calc_q;
	logic [7:0] recv_q;
	logic [6:0] index_q;

	logic half_eff;
	logic [6:0] count_eff;
	logic emit;
	logic [31:0] emit_word;

	assign cfg_ready = 1'b1;
	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	// a fresh transaction starts a new response: drop pending half and count
	always_comb begin
		half_eff = head.fresh ? 1'b0 : half_q;
		count_eff = head.fresh ? 7'd0 : count_q;
		emit = !head.ok || !pair_mode_q || half_eff;
		if (!head.ok) begin
			emit_word = 32'd0;
		end else if (!pair_mode_q) begin
			emit_word = {16'd0, head.word};
		end else begin
			emit_word = {upper_q, head.word};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_mode_q <= 1'b1;
			half_q <= 1'b0;
			count_q <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pair_mode_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				half_q <= head.ok && pair_mode_q && !half_eff;
				count_q <= count_eff;
				if (emit) begin
					out_valid_q <= 1'b1;
					count_q <= (count_eff == CountMax) ? CountMax : count_eff + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (head.ok && pair_mode_q && !half_eff) begin
				upper_q <= head.word;
			end
			if (emit) begin
				word_q <= emit_word;
				ok_q <= head.ok;
				calc_q <= head.calc;
				recv_q <= head.recv;
				index_q <= count_eff;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign word_value = word_q;
	assign crc_ok = ok_q;
	assign computed_crc = calc_q;
	assign received_crc = recv_q;
	assign word_index = index_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 8;
	localparam int PhaseBytes = 180;
	localparam int RandomPhases = 7;

	typedef struct packed {
		logic [7:0] data;
		logic start;
	} rx_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic ok;
		logic [7:0] calc;
		logic [7:0] recv;
		logic [6:0] index;
	} deframed_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic start_of_read = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] word_value;
	logic crc_ok;
	logic [7:0] computed_crc;
	logic [7:0] received_crc;
	logic [6:0] word_index;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	crc8_checked_word_deframer_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.start_of_read(start_of_read),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.word_value(word_value),
		.crc_ok(crc_ok),
		.computed_crc(computed_crc),
		.received_crc(received_crc),
		.word_index(word_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	rx_item_t pending_bytes[$];
	deframed_word_t expected_words[$];

	// shadow of the deframer state
	logic mode_shadow = 1'b1;
	logic [1:0] trip_pos = 2'd0;
	logic [7:0] first_byte = 8'h00;
	logic [7:0] second_byte = 8'h00;
	logic [15:0] upper_half = 16'h0000;
	logic half_pending = 1'b0;
	logic aborted = 1'b0;
	logic [6:0] emitted = 7'd0;

	logic in_fire = 1'b0;
	rx_item_t next_item;
	deframed_word_t want;
	int in_gap = 0;
	int stall_left = 0;
	int idle_odds = 6;
	int cycle_count = 0;
	int n_fail = 0;
	int n_pushed = 0;
	int n_results = 0;
	int n_crc_errors = 0;
	int n_saturated = 0;
	int n_mode_writes = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// bitwise msb-first crc-8, poly 0x31
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
		end
		return c;
	endfunction

	task automatic post_result(input logic [31:0] word, input logic ok,
			input logic [7:0] calc, input logic [7:0] recv);
		expected_words.push_back('{word: word, ok: ok, calc: calc, recv: recv,
			index: emitted});
		if (emitted != c8wd_pkg::CountMax) begin
			emitted = emitted + 7'd1;
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic start);
		logic [7:0] calc;
		logic [15:0] word;
		if (start) begin
			trip_pos = 2'd0;
			half_pending = 1'b0;
			aborted = 1'b0;
			emitted = 7'd0;
		end
		if (aborted) begin
			return;
		end
		if (trip_pos == 2'd3) begin
			trip_pos = 2'd0;
		end
		case (trip_pos)
			2'd0: begin
				first_byte = b;
				trip_pos = 2'd1;
			end
			2'd1: begin
				second_byte = b;
				trip_pos = 2'd2;
			end
			default: begin
				trip_pos = 2'd0;
				calc = crc8_update(crc8_update(c8wd_pkg::CrcInit, first_byte), second_byte);
				word = {first_byte, second_byte};
				if (calc != b) begin
					aborted = 1'b1;
					half_pending = 1'b0;
					post_result(32'd0, 1'b0, calc, b);
				end else if (!mode_shadow) begin
					half_pending = 1'b0;
					post_result({16'd0, word}, 1'b1, calc, b);
				end else if (!half_pending) begin
					upper_half = word;
					half_pending = 1'b1;
				end else begin
					half_pending = 1'b0;
					post_result({upper_half, word}, 1'b1, calc, b);
				end
			end
		endcase
	endtask

	// monitor: predict on accepted bytes, check accepted results
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (arst_n && cfg_valid && cfg_ready) begin
			mode_shadow = cfg_data;
		end
		if (in_fire) begin
			deframe_byte(rx_byte, start_of_read);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected result word %h crc_ok %b crc %h/%h index %0d",
					$time, word_value, crc_ok, computed_crc, received_crc, word_index);
				n_fail++;
			end else begin
				want = expected_words.pop_front();
				n_results++;
				if (!want.ok) n_crc_errors++;
				if (want.index == c8wd_pkg::CountMax) n_saturated++;
				if (word_value !== want.word || crc_ok !== want.ok ||
						computed_crc !== want.calc || received_crc !== want.recv ||
						word_index !== want.index) begin
					$display("%0t: expected word %h ok %b crc %h/%h index %0d", $time,
						want.word, want.ok, want.calc, want.recv, want.index);
					$display("%0t: actual   word %h ok %b crc %h/%h index %0d", $time,
						word_value, crc_ok, computed_crc, received_crc, word_index);
					n_fail++;
				end
			end
		end
	end

	// byte driver; a stalled transaction holds its payload
	always @(negedge clk) begin
		if (in_valid && !in_fire) begin
			// hold
		end else if (idle_odds != 0 && in_gap != 0) begin
			in_valid <= 1'b0;
			in_gap = in_gap - 1;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			in_gap = $urandom_range(0, 17);
		end else if (arst_n && pending_bytes.size() != 0) begin
			next_item = pending_bytes.pop_front();
			in_valid <= 1'b1;
			rx_byte <= next_item.data;
			start_of_read <= next_item.start;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result-side stall bursts
	always @(negedge clk) begin
		if (idle_odds != 0 && stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds * 2) == 1) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d results outstanding", $time, expected_words.size());
		$display("FAIL");
		$finish;
	end

	task automatic push_byte(input logic [7:0] data, input logic start);
		pending_bytes.push_back('{data: data, start: start});
		n_pushed++;
	endtask

	task automatic push_triplet(input logic [7:0] d0, input logic [7:0] d1,
			input logic bad, input logic start);
		logic [7:0] crc;
		crc = crc8_update(crc8_update(8'hFF, d0), d1);
		if (bad) begin
			crc = crc ^ 8'($urandom_range(1, 255));
		end
		push_byte(d0, start);
		push_byte(d1, 1'b0);
		push_byte(crc, 1'b0);
	endtask

	function automatic logic [7:0] rand_data();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_response(input int ntrip, input logic start);
		logic bad;
		for (int t = 0; t < ntrip; t++) begin
			bad = ($urandom_range(0, 15) == 0);
			push_triplet(rand_data(), rand_data(), bad, start && t == 0);
			if (bad) begin
				// bytes after a mismatch go nowhere
				repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0);
				return;
			end
		end
		// truncated tail, cut off by the next start byte
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 2)) push_byte(rand_data(), 1'b0);
		end
	endtask

	// waits out every expected result plus the pipeline of resultless bytes
	task automatic settle_idle();
		while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_pair_mode(input logic mode);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_mode_writes++;
	endtask

	initial begin
		logic mode;
		int target;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pair mode from reset: pair, error, ignored bytes, pending half
		push_triplet(8'h00, 8'h00, 1'b0, 1'b1);
		push_triplet(8'hFF, 8'hFF, 1'b0, 1'b0);
		push_triplet(8'h12, 8'h34, 1'b1, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b0);
		push_triplet(8'hBE, 8'hEF, 1'b0, 1'b1);
		settle_idle();
		// single mode drops the pending upper half
		set_pair_mode(1'b0);
		push_triplet(8'hC3, 8'h3C, 1'b0, 1'b0);
		push_triplet(8'hFF, 8'h00, 1'b1, 1'b0);
		push_byte(8'h80, 1'b1);
		push_triplet(8'h7F, 8'h01, 1'b0, 1'b1);

		for (int p = 0; p < RandomPhases; p++) begin
			settle_idle();
			case (p)
				0, 2: mode = 1'b1;
				1, 3: mode = 1'b0;
				default: mode = 1'($urandom_range(0, 1));
			endcase
			set_pair_mode(mode);
			if (p == RandomPhases - 1) begin
				idle_odds = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_odds = 3;
					1: idle_odds = 10;
					default: idle_odds = 40;
				endcase
			end
			// one long response to run the word index into saturation
			if (p == 1) begin
				for (int t = 0; t < 135; t++) begin
					push_triplet(rand_data(), rand_data(), 1'b0, t == 0);
				end
			end
			target = n_pushed + PhaseBytes;
			// first response may continue across the mode write
			push_response($urandom_range(1, 10), 1'($urandom_range(0, 1)));
			while (n_pushed < target) begin
				if ($urandom_range(0, 11) == 0) begin
					push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else begin
					push_response($urandom_range(1, 10), $urandom_range(0, 7) != 0);
				end
			end
		end
		settle_idle();

		$display("sent %0d bytes over %0d pair_mode writes, single and pair framing",
			n_pushed, n_mode_writes);
		$display("checked %0d results: %0d crc errors, %0d at saturated index",
			n_results, n_crc_errors, n_saturated);
		if (n_fail == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
